// ===== design/hsvp_pkg.sv =====
// Shared constants, sector codes and fixed-point helpers for the HSV to RGB pipeline.
package hsvp_pkg;

  localparam int HUE_W = 9;
  localparam int PCT_W = 7;
  localparam int CH_W  = 8;
  localparam int SEC_W = 3;

  localparam logic [HUE_W-1:0] HUE_WRAP = 9'd360;
  localparam logic [HUE_W-1:0] SEC_SPAN = 9'd60;
  localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;
  localparam logic [CH_W-1:0]  CH_MAX   = 8'd255;
  localparam logic [CH_W-1:0]  BRIGHT_RESET = 8'd255;

  // 5243 / 2^19 approximates 1/100 closely enough for numerators below 2^15.
  localparam logic [12:0] RECIP_100 = 13'd5243;

  localparam logic [SEC_W-1:0] SEC_RED_YEL   = 3'd0;
  localparam logic [SEC_W-1:0] SEC_YEL_GRN   = 3'd1;
  localparam logic [SEC_W-1:0] SEC_GRN_CYN   = 3'd2;
  localparam logic [SEC_W-1:0] SEC_CYN_BLU   = 3'd3;
  localparam logic [SEC_W-1:0] SEC_BLU_MAG   = 3'd4;
  localparam logic [SEC_W-1:0] SEC_MAG_RED   = 3'd5;

  typedef logic [CH_W-1:0] chan_t;

  // Exact floor(y / 255) for any 16-bit y below 65280, i.e. whenever the quotient fits in 8 bits.
  function automatic chan_t div255(input logic [15:0] y);
    logic [16:0] sum;
    sum = {1'b0, y} + {9'd0, y[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

  // Clamp a percent to 100, then scale to 0..255 with truncation.
  function automatic chan_t pct_to_byte(input logic [PCT_W-1:0] x);
    logic [PCT_W-1:0] xc;
    logic [14:0]      y;
    logic [27:0]      prod;
    xc   = (x > PCT_MAX) ? PCT_MAX : x;
    y    = {8'd0, xc} * 15'd255;
    prod = {13'd0, y} * {15'd0, RECIP_100};
    return prod[26:19];
  endfunction

endpackage

// ===== design/hsv_percent_to_rgb.sv =====
// Percent HSV to 8-bit RGB converter, four-stage pipeline with brightness scaling.
// Throughput: one beat per cycle; each stage holds while the one after it is full and stalled.
// Stages: percent scaling and hue split, S*rem products, V scaling, sector select and dimming.
// Reset (rst, synchronous): clears all stage valid bits and sets brightness to 255.
module hsv_percent_to_rgb (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [hsvp_pkg::CH_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hsvp_pkg::HUE_W-1:0]  hue,
  input  logic [hsvp_pkg::PCT_W-1:0]  saturation,
  input  logic [hsvp_pkg::PCT_W-1:0]  value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hsvp_pkg::CH_W-1:0]   red,
  output logic [hsvp_pkg::CH_W-1:0]   green,
  output logic [hsvp_pkg::CH_W-1:0]   blue
);
  import hsvp_pkg::*;

  chan_t brightness;

  // stage valid bits and enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  // stage 1 registers
  chan_t            s1_sat, s1_val, s1_rem;
  logic [SEC_W-1:0] s1_sec;
  // stage 2 registers
  chan_t            s2_val, s2_pf, s2_qf, s2_tf;
  logic [SEC_W-1:0] s2_sec;
  // stage 3 registers
  chan_t            s3_val, s3_p, s3_q, s3_t;
  logic [SEC_W-1:0] s3_sec;

  // stage 1 logic
  logic [HUE_W-1:0] hc;
  logic [SEC_W-1:0] sec_c;
  logic [HUE_W-1:0] sec_base;
  logic [HUE_W-1:0] hrem;
  logic [9:0]       rem17;
  chan_t            rem_c;

  // stage 2 logic
  logic [15:0] prod_q, prod_t;

  // stage 3 logic
  logic [15:0] prod_p3, prod_q3, prod_t3;

  // stage 4 logic
  chan_t       r_sel, g_sel, b_sel;
  logic [15:0] prod_r, prod_g, prod_b;

  assign en4      = !v4 || !out_stall;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= BRIGHT_RESET;
    end else if (cfg_we) begin
      brightness <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Stage 1: wrap hue, split into sector and scaled remainder, scale percents.
  always_comb begin
    hc = (hue >= HUE_WRAP) ? '0 : hue;
    if (hc < SEC_SPAN) begin
      sec_c = SEC_RED_YEL;
      sec_base = 9'd0;
    end else if (hc < 9'd120) begin
      sec_c = SEC_YEL_GRN;
      sec_base = 9'd60;
    end else if (hc < 9'd180) begin
      sec_c = SEC_GRN_CYN;
      sec_base = 9'd120;
    end else if (hc < 9'd240) begin
      sec_c = SEC_CYN_BLU;
      sec_base = 9'd180;
    end else if (hc < 9'd300) begin
      sec_c = SEC_BLU_MAG;
      sec_base = 9'd240;
    end else begin
      sec_c = SEC_MAG_RED;
      sec_base = 9'd300;
    end
    hrem  = hc - sec_base;
    // rem * 255 / 60 is rem * 17 / 4 exactly
    rem17 = {4'd0, hrem[5:0]} * 10'd17;
    rem_c = rem17[9:2];
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sat <= pct_to_byte(saturation);
      s1_val <= pct_to_byte(value);
      s1_sec <= sec_c;
      s1_rem <= rem_c;
    end
  end

  // Stage 2: S*rem and S*(255-rem), form the three V multipliers.
  assign prod_q = {8'd0, s1_sat} * {8'd0, s1_rem};
  assign prod_t = {8'd0, s1_sat} * {8'd0, CH_MAX - s1_rem};

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_val <= s1_val;
      s2_sec <= s1_sec;
      s2_pf  <= CH_MAX - s1_sat;
      s2_qf  <= CH_MAX - div255(prod_q);
      s2_tf  <= CH_MAX - div255(prod_t);
    end
  end

  // Stage 3: scale by V. Zero saturation makes p, q and t all equal V.
  assign prod_p3 = {8'd0, s2_val} * {8'd0, s2_pf};
  assign prod_q3 = {8'd0, s2_val} * {8'd0, s2_qf};
  assign prod_t3 = {8'd0, s2_val} * {8'd0, s2_tf};

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_val <= s2_val;
      s3_sec <= s2_sec;
      s3_p   <= div255(prod_p3);
      s3_q   <= div255(prod_q3);
      s3_t   <= div255(prod_t3);
    end
  end

  // Stage 4: route levels by sector, then dim by brightness.
  always_comb begin
    unique case (s3_sec)
      SEC_RED_YEL: begin
        r_sel = s3_val; g_sel = s3_t;   b_sel = s3_p;
      end
      SEC_YEL_GRN: begin
        r_sel = s3_q;   g_sel = s3_val; b_sel = s3_p;
      end
      SEC_GRN_CYN: begin
        r_sel = s3_p;   g_sel = s3_val; b_sel = s3_t;
      end
      SEC_CYN_BLU: begin
        r_sel = s3_p;   g_sel = s3_q;   b_sel = s3_val;
      end
      SEC_BLU_MAG: begin
        r_sel = s3_t;   g_sel = s3_p;   b_sel = s3_val;
      end
      default: begin
        r_sel = s3_val; g_sel = s3_p;   b_sel = s3_q;
      end
    endcase
  end

  assign prod_r = {8'd0, r_sel} * {8'd0, brightness};
  assign prod_g = {8'd0, g_sel} * {8'd0, brightness};
  assign prod_b = {8'd0, b_sel} * {8'd0, brightness};

  always_ff @(posedge clk) begin
    if (en4) begin
      red   <= div255(prod_r);
      green <= div255(prod_g);
      blue  <= div255(prod_b);
    end
  end

endmodule
